### hdl/ntc_thermistor_beta_converter_assert.svh
// Assertion macros shared by the thermistor converter RTL.
// Clock is "clock", synchronous active-high reset is "reset".
`ifndef NTC_THERMISTOR_BETA_CONVERTER_ASSERT_SVH
`define NTC_THERMISTOR_BETA_CONVERTER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define NTCB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication, outside reset.
`define NTCB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hdl/ntcb_pkg.sv
// Shared types and constants for the thermistor converter.
// No dependencies.
`timescale 1ns / 1ps
package ntcb_pkg;
   // shared divider geometry
   localparam int DIV_W = 67;
   localparam int DVS_W = 50;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // register defaults and sizes
   localparam int DEF_SAMPLE_COUNT = 5;
   localparam int CSR_DW = 24;
   localparam int CSR_AW = 3;
   localparam logic [14:0] DEF_FULL_SCALE = 15'd26400;
   localparam logic [23:0] DEF_SERIES = 24'd100300;
   localparam logic [23:0] DEF_NOMINAL = 24'd100000;
   localparam logic [15:0] DEF_BETA = 16'd3950;
   localparam logic signed [8:0] DEF_NOM_TEMP = 9'sd25;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage

### hdl/ntcb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ntcb_pkg and the assertion macro header.
`timescale 1ns / 1ps
module ntcb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ntcb_pkg::DIV_W-1:0]  dividend,
   input  logic [ntcb_pkg::DVS_W-1:0]  divisor,
   output logic [ntcb_pkg::DIV_W-1:0]  quotient,
   output ntcb_pkg::div_stat_type      stat
);
   import ntcb_pkg::*;
   `include "ntc_thermistor_beta_converter_assert.svh"

   localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W:0]       rem_sh;
   logic [DVS_W+1:0]     diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, rem_sh} - {2'b0, dvs_ff};
      if (busy_ff) begin
         if (!diff[DVS_W+1]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cnt_in  = '0;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `NTCB_ASSERT_IMP(a_done_idle, done_ff, !busy_ff, "divider done while busy")
   `NTCB_ASSERT(a_start_busy, (start && !busy_ff) |=> busy_ff, "divider failed to start")
   `NTCB_ASSERT(a_last_done, (busy_ff && cnt_ff == LAST) |=> done_ff, "divider missed done")
   `NTCB_ASSERT_IMP(a_idle_cnt, !busy_ff, cnt_ff == '0, "divider count not cleared")
endmodule

### hdl/ntc_thermistor_beta_converter.sv
// NTC thermistor converter, beta equation, top level.
// Uses ntcb_pkg, ntcb_div and the assertion macro header.
//
// Usage:
//  req_* : one signed ADC reading per request (req_valid / req_stall).
//  rsp_* : one result per SAMPLE_COUNT requests: average (1/16 code),
//          resistance (ohms), temperature (1/256 C) and a status code.
//  csr_* : register writes (index, data); always ready. Write only when idle.
//  Readings are summed; requests are taken in one cycle each while no
//  result is being computed. The request that completes a group starts the
//  computation and req_stall stays high until the result is in the output
//  register. From the last request of a group to rsp_valid the work is two
//  passes through the bit-serial divider, three base-2 logs (shift search,
//  then 30 square-and-compare steps on the shared 32x32 multiplier) and
//  reciprocal multiplies for the divides by SAMPLE_COUNT and by 5, plus any
//  wait for the output slot. Low or full-scale readings skip the divider
//  and the logs.
//  The result is held in rsp_* while rsp_stall is high; new readings are
//  still taken meanwhile, only the next result waits for the slot.
//  Reset clears the sum, count and output valid and loads register defaults.
`timescale 1ns / 1ps
module ntc_thermistor_beta_converter #(
   parameter int SAMPLE_COUNT = ntcb_pkg::DEF_SAMPLE_COUNT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [15:0]          req_adc_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [18:0]                 rsp_average_q4,
   output logic [31:0]                 rsp_resistance_ohms,
   output logic signed [17:0]          rsp_temperature_q8,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ntcb_pkg::CSR_AW-1:0] csr_index,
   input  logic [ntcb_pkg::CSR_DW-1:0] csr_data
);
   import ntcb_pkg::*;
   `include "ntc_thermistor_beta_converter_assert.svh"

   localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int SUM_W = 16 + $clog2(SAMPLE_COUNT);
   localparam int FSN_W = 22;
   localparam int HALF_N = SAMPLE_COUNT / 2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_LOW  = 2'd1;
   localparam logic [1:0] ST_HIGH = 2'd2;
   localparam logic [1:0] ST_SAT  = 2'd3;

   localparam logic [CSR_AW-1:0] REG_FULL_SCALE = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] REG_SERIES     = CSR_AW'(1);
   localparam logic [CSR_AW-1:0] REG_NOMINAL    = CSR_AW'(2);
   localparam logic [CSR_AW-1:0] REG_BETA       = CSR_AW'(3);
   localparam logic [CSR_AW-1:0] REG_NOM_TEMP   = CSR_AW'(4);

   localparam logic [31:0] LN2_Q30 = 32'd744261118;
   localparam logic [DIV_W-1:0] T_LIMIT = DIV_W'(5) << 20;
   localparam logic signed [17:0] TEMP_MAX = 18'sd131071;
   // ceil(2^31 / N): exact floor for every rounded sum*16 the group can give
   localparam logic [31:0] AVG_RECIP =
      32'(((64'd1 << 31) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
   // ceil(2^26 / 5): exact floor below 2^26
   localparam logic [31:0] DIV5_RECIP = 32'd13421773;

   typedef enum logic [4:0] {
      S_IDLE, S_FSN, S_AVG, S_AVGW, S_NUM, S_NUMW, S_RESW, S_NORM, S_SQ, S_SQW,
      S_LN, S_LNW, S_LK, S_LKW, S_BK, S_BKW, S_B100, S_DD, S_TW, S_TCW, S_OUT
   } state_type;

   // configuration registers
   logic [14:0]       fs_ff;
   logic [23:0]       series_ff;
   logic [23:0]       nom_ff;
   logic [15:0]       beta_ff;
   logic signed [8:0] ntc_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff     <= DEF_FULL_SCALE;
         series_ff <= DEF_SERIES;
         nom_ff    <= DEF_NOMINAL;
         beta_ff   <= DEF_BETA;
         ntc_ff    <= DEF_NOM_TEMP;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FULL_SCALE: fs_ff     <= csr_data[14:0];
            REG_SERIES:     series_ff <= csr_data[23:0];
            REG_NOMINAL:    nom_ff    <= csr_data[23:0];
            REG_BETA:       beta_ff   <= csr_data[15:0];
            REG_NOM_TEMP:   ntc_ff    <= signed'(csr_data[8:0]);
            default: ;
         endcase
      end
   end

   // datapath and control state
   state_type               state_ff, state_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, tot_ff, tot_in, sum_next;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FSN_W-1:0]        fsn_ff, fsn_in, den_ff, den_in, den_calc;
   logic [45:0]             num_ff, num_in;
   logic [18:0]             avg_ff, avg_in;
   logic [31:0]             res_ff, res_in;
   logic signed [17:0]      tc_ff, tc_in;
   logic [1:0]              status_ff, status_in;
   logic [63:0]             x_ff, x_in;
   logic [5:0]              e_ff, e_in;
   logic [30:0]             m_ff, m_in;
   logic [35:0]             lacc_ff, lacc_in;
   logic [4:0]              bit_ff, bit_in;
   logic [1:0]              which_ff, which_in;
   logic [35:0]             l0_ff, l0_in, l1_ff, l1_in, l2_ff, l2_in;
   logic [31:0]             lm_ff, lm_in, bk_ff, bk_in;
   logic [47:0]             lk_ff, lk_in;
   logic [63:0]             prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [18:0]             rsp_avg_ff, rsp_avg_in;
   logic [31:0]             rsp_res_ff, rsp_res_in;
   logic signed [17:0]      rsp_tc_ff, rsp_tc_in;
   logic [1:0]              rsp_st_ff, rsp_st_in;

   logic [31:0]             mul_a, mul_b;
   logic                    div_start;
   logic [DIV_W-1:0]        div_dvd, div_quot;
   logic [DVS_W-1:0]        div_dvs;
   div_stat_type            div_stat;

   logic signed [17:0]      k_s;
   logic [15:0]             k16;
   logic signed [37:0]      d_s, mag_s;
   logic [31:0]             sq;
   logic [35:0]             lacc_next;
   logic [63:0]             lmp;
   logic signed [49:0]      lq_s, dd_s;
   logic signed [22:0]      tcv;

   ntcb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // K = 100*T0 + 27315, always positive over the 9-bit register range
   assign k_s = 18'(ntc_ff) * 18'sd100 + 18'sd27315;
   assign k16 = k_s[15:0];
   // log2(num) - log2(den) - log2(R0), Q30
   assign d_s   = signed'({2'b0, l0_ff}) - signed'({2'b0, l1_ff})
                  - signed'({2'b0, l2_ff});
   assign mag_s = d_s[37] ? -d_s : d_s;
   assign sq    = prod_ff[61:30];
   assign lmp   = prod_ff + 64'd536870912;
   assign lq_s  = signed'({2'b0, lk_ff});
   assign dd_s  = (d_s[37] ? -lq_s : lq_s) + signed'({3'b0, prod_ff[22:0], 24'b0});
   // (t + 370) / 5 by reciprocal, less the offset
   assign tcv   = signed'({2'b0, prod_ff[46:26]}) - 23'sd70000;
   assign den_calc = fsn_ff - FSN_W'(unsigned'(tot_ff));
   assign sum_next = sum_ff + SUM_W'(req_adc_sample);

   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      tot_in    = tot_ff;
      cnt_in    = cnt_ff;
      fsn_in    = fsn_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      avg_in    = avg_ff;
      res_in    = res_ff;
      tc_in     = tc_ff;
      status_in = status_ff;
      x_in      = x_ff;
      e_in      = e_ff;
      m_in      = m_ff;
      lacc_in   = lacc_ff;
      bit_in    = bit_ff;
      which_in  = which_ff;
      l0_in     = l0_ff;
      l1_in     = l1_ff;
      l2_in     = l2_ff;
      lm_in     = lm_ff;
      lk_in     = lk_ff;
      bk_in     = bk_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_res_in = rsp_res_ff;
      rsp_tc_in  = rsp_tc_ff;
      rsp_st_in  = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      lacc_next = lacc_ff;
      req_stall = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (cnt_ff == CNT_W'(SAMPLE_COUNT - 1)) begin
                  tot_in   = sum_next;
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = S_FSN;
               end else begin
                  sum_in = sum_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_FSN: begin
            mul_a    = 32'(fs_ff);
            mul_b    = 32'(SAMPLE_COUNT);
            state_in = S_AVG;
         end
         S_AVG: begin
            fsn_in    = prod_ff[FSN_W-1:0];
            avg_in    = '0;
            res_in    = '0;
            tc_in     = '0;
            status_in = ST_OK;
            if (tot_ff <= 0) begin
               status_in = ST_LOW;
               state_in  = S_OUT;
            end else begin
               // (16*sum + N/2) / N by reciprocal
               mul_a    = (32'(unsigned'(tot_ff)) << 4) + 32'(HALF_N);
               mul_b    = AVG_RECIP;
               state_in = S_AVGW;
            end
         end
         S_AVGW: begin
            avg_in = prod_ff[49:31];
            if (FSN_W'(unsigned'(tot_ff)) >= fsn_ff) begin
               status_in = ST_HIGH;
               state_in  = S_OUT;
            end else begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            mul_a    = 32'(series_ff);
            mul_b    = 32'(unsigned'(tot_ff));
            state_in = S_NUMW;
         end
         S_NUMW: begin
            num_in    = prod_ff[45:0];
            den_in    = den_calc;
            div_start = 1'b1;
            div_dvd   = DIV_W'(prod_ff[45:0]) + DIV_W'(den_calc >> 1);
            div_dvs   = DVS_W'(den_calc);
            state_in  = S_RESW;
         end
         S_RESW: begin
            if (div_stat.done) begin
               if (|div_quot[DIV_W-1:32]) begin
                  res_in    = 32'hFFFF_FFFF;
                  status_in = ST_SAT;
               end else begin
                  res_in = div_quot[31:0];
               end
               if (series_ff == '0 || nom_ff == '0 || beta_ff == '0) begin
                  status_in = ST_SAT;
                  state_in  = S_OUT;
               end else begin
                  x_in     = 64'(num_ff);
                  e_in     = 6'd63;
                  which_in = 2'd0;
                  state_in = S_NORM;
               end
            end
         end
         // shift until the leading one reaches the top bit
         S_NORM: begin
            if (x_ff[63]) begin
               m_in     = x_ff[63:33];
               lacc_in  = {e_ff, 30'b0};
               bit_in   = 5'd29;
               state_in = S_SQ;
            end else begin
               x_in = x_ff << 1;
               e_in = e_ff - 1'b1;
            end
         end
         S_SQ: begin
            mul_a    = 32'(m_ff);
            mul_b    = 32'(m_ff);
            state_in = S_SQW;
         end
         S_SQW: begin
            if (sq[31]) begin
               m_in      = sq[31:1];
               lacc_next = lacc_ff | (36'd1 << bit_ff);
            end else begin
               m_in = sq[30:0];
            end
            lacc_in = lacc_next;
            if (bit_ff == '0) begin
               case (which_ff)
                  2'd0: begin
                     l0_in    = lacc_next;
                     x_in     = 64'(den_ff);
                     e_in     = 6'd63;
                     which_in = 2'd1;
                     state_in = S_NORM;
                  end
                  2'd1: begin
                     l1_in    = lacc_next;
                     x_in     = 64'(nom_ff);
                     e_in     = 6'd63;
                     which_in = 2'd2;
                     state_in = S_NORM;
                  end
                  default: begin
                     l2_in    = lacc_next;
                     state_in = S_LN;
                  end
               endcase
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = S_SQ;
            end
         end
         S_LN: begin
            mul_a    = mag_s[37:6];
            mul_b    = LN2_Q30;
            state_in = S_LNW;
         end
         S_LNW: begin
            lm_in    = lmp[61:30];
            state_in = S_LK;
         end
         S_LK: begin
            mul_a    = lm_ff;
            mul_b    = 32'(k16);
            state_in = S_LKW;
         end
         S_LKW: begin
            lk_in    = prod_ff[47:0];
            state_in = S_BK;
         end
         S_BK: begin
            mul_a    = 32'(beta_ff);
            mul_b    = 32'(k16);
            state_in = S_BKW;
         end
         S_BKW: begin
            bk_in    = prod_ff[31:0];
            state_in = S_B100;
         end
         S_B100: begin
            mul_a    = 32'(beta_ff);
            mul_b    = 32'd100;
            state_in = S_DD;
         end
         // denominator L*K + 100*B*2^24; 5*kelvin in 1/256 K = 5*B*K*2^32 / that
         S_DD: begin
            if (dd_s[49] || dd_s == '0) begin
               tc_in     = TEMP_MAX;
               status_in = ST_SAT;
               state_in  = S_OUT;
            end else begin
               div_start = 1'b1;
               div_dvd   = {1'b0, bk_ff, 34'b0} + {3'b0, bk_ff, 32'b0};
               div_dvs   = DVS_W'(unsigned'(dd_s));
               state_in  = S_TW;
            end
         end
         S_TW: begin
            if (div_stat.done) begin
               if (div_quot >= T_LIMIT) begin
                  tc_in     = TEMP_MAX;
                  status_in = ST_SAT;
                  state_in  = S_OUT;
               end else begin
                  mul_a    = 32'(div_quot[22:0]) + 32'd370;
                  mul_b    = DIV5_RECIP;
                  state_in = S_TCW;
               end
            end
         end
         S_TCW: begin
            if (tcv > 23'sd131071) begin
               tc_in     = TEMP_MAX;
               status_in = ST_SAT;
            end else begin
               tc_in = tcv[17:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_res_in   = (status_ff == ST_HIGH) ? 32'd0 : res_ff;
               rsp_tc_in    = tc_ff;
               rsp_st_in    = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tot_ff     <= tot_in;
      fsn_ff     <= fsn_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      avg_ff     <= avg_in;
      res_ff     <= res_in;
      tc_ff      <= tc_in;
      status_ff  <= status_in;
      x_ff       <= x_in;
      e_ff       <= e_in;
      m_ff       <= m_in;
      lacc_ff    <= lacc_in;
      bit_ff     <= bit_in;
      which_ff   <= which_in;
      l0_ff      <= l0_in;
      l1_ff      <= l1_in;
      l2_ff      <= l2_in;
      lm_ff      <= lm_in;
      lk_ff      <= lk_in;
      bk_ff      <= bk_in;
      prod_ff    <= prod_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_res_ff <= rsp_res_in;
      rsp_tc_ff  <= rsp_tc_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // shared multiplier, product registered
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average_q4      = rsp_avg_ff;
   assign rsp_resistance_ohms = rsp_res_ff;
   assign rsp_temperature_q8  = rsp_tc_ff;
   assign rsp_status          = rsp_st_ff;

   `NTCB_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider started while busy")
   `NTCB_ASSERT_IMP(a_low_zero, rsp_valid && rsp_status == ST_LOW,
      rsp_average_q4 == '0 && rsp_resistance_ohms == '0 && rsp_temperature_q8 == '0,
      "low reading result not cleared")
   `NTCB_ASSERT_IMP(a_high_zero, rsp_valid && rsp_status == ST_HIGH,
      rsp_resistance_ohms == '0 && rsp_temperature_q8 == '0,
      "full scale result not cleared")
   `NTCB_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(SAMPLE_COUNT - 1), "sample count out of range")
endmodule

### tb/ntc_thermistor_beta_converter_test.sv
// Self-checking bench for the NTC thermistor beta-equation converter.
// Uses ntcb_pkg and the converter top level; predicts every result in place.
`timescale 1ns / 1ps
module ntc_thermistor_beta_converter_test;
   import ntcb_pkg::*;

   localparam int N_SAMPLES   = DEF_SAMPLE_COUNT;
   localparam int N_RANDOM    = 1800;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int DRAIN_WAIT  = 1500;
   localparam logic [1:0] ST_OK = 2'd0, ST_LOW = 2'd1, ST_HIGH = 2'd2, ST_SAT = 2'd3;
   localparam logic [2:0] R_FULL = 3'd0, R_SERIES = 3'd1, R_NOMINAL = 3'd2,
                          R_BETA = 3'd3, R_NOMTEMP = 3'd4;
   localparam longint LN2_Q30 = 744261118;
   localparam longint TEMP_MAX = 131071;

   typedef struct packed {
      logic [18:0]        average_q4;
      logic [31:0]        resistance_ohms;
      logic signed [17:0] temperature_q8;
      logic [1:0]         status;
   } reading_type;

   // directed row: sample plus an optional hand-typed result
   typedef struct {
      logic signed [15:0] sample;
      bit                 typed;
      reading_type        want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_adc_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [18:0] rsp_average_q4;
   logic [31:0] rsp_resistance_ohms;
   logic signed [17:0] rsp_temperature_q8;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   always #4 clock = ~clock;

   ntc_thermistor_beta_converter u_dut (.*);

   // predictor copy of registers and accumulator
   logic [14:0] m_full;
   logic [23:0] m_series, m_nominal;
   logic [15:0] m_beta;
   logic signed [8:0] m_nomtemp;
   longint m_sum;
   int m_count;

   reading_type expected_q[$];
   reading_type typed_q[$];   // hand-typed rows, checked in addition
   bit          typed_flag_q[$];
   int mismatches = 0, results_seen = 0, cycles = 0;
   int stall_left = 0;
   bit no_idle = 0;

   function automatic longint log2_q30(longint unsigned x);
      int e;
      longint unsigned m;
      longint r;
      e = 63;
      while (e > 0 && x[e] == 1'b0) e--;
      if (e >= 30) m = x >> (e - 30);
      else m = x << (30 - e);
      r = longint'(e) << 30;
      for (int b = 29; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            r += longint'(1) << b;
         end
      end
      return r;
   endfunction

   // convert a finished sum into the expected result
   function automatic reading_type convert_sum(longint sum);
      reading_type o;
      longint unsigned fsn, num, den, res, mag, lm, nn, q, r, t;
      longint d, lq, k, dd, tc;
      bit hot;
      o = '0;
      o.status = ST_OK;
      res = 0;
      tc = 0;
      fsn = longint'(m_full) * N_SAMPLES;
      if (sum <= 0) begin
         o.status = ST_LOW;
      end else begin
         o.average_q4 = 19'((sum * 16 + N_SAMPLES / 2) / N_SAMPLES);
         if (longint'(sum) >= fsn) begin
            o.status = ST_HIGH;
         end else begin
            num = longint'(m_series) * sum;
            den = fsn - sum;
            res = (num + den / 2) / den;
            if (res > 64'hFFFF_FFFF) begin
               res = 64'hFFFF_FFFF;
               o.status = ST_SAT;
            end
            if (m_series == 0 || m_nominal == 0 || m_beta == 0) begin
               o.status = ST_SAT;
            end else begin
               d = log2_q30(num) - log2_q30(den) - log2_q30(m_nominal);
               mag = d < 0 ? -d : d;
               lm = ((mag >> 6) * LN2_Q30 + (64'd1 << 29)) >> 30;
               lq = d < 0 ? -longint'(lm) : longint'(lm);
               k = 100 * longint'(m_nomtemp) + 27315;
               dd = lq * k + 100 * longint'(m_beta) * (longint'(1) << 24);
               hot = 0;
               if (dd <= 0) hot = 1;
               else begin
                  nn = (longint'(m_beta) * k) << 32;
                  q = nn / dd;
                  r = nn % dd;
                  if (q >= (64'd1 << 20)) hot = 1;
                  else begin
                     t = 5 * q + (5 * r) / dd;
                     tc = longint'((t + 370) / 5) - 70000;
                     if (tc > TEMP_MAX) hot = 1;
                  end
               end
               if (hot) begin
                  tc = TEMP_MAX;
                  o.status = ST_SAT;
               end
            end
         end
      end
      if (o.status == ST_HIGH) res = 0;
      o.resistance_ohms = res[31:0];
      o.temperature_q8 = tc[17:0];
      return o;
   endfunction

   function automatic void predict_sample(logic signed [15:0] s, bit typed, reading_type w);
      m_sum += s;
      if (m_count + 1 < N_SAMPLES) begin
         m_count++;
         return;
      end
      expected_q.push_back(convert_sum(m_sum));
      typed_flag_q.push_back(typed);
      typed_q.push_back(w);
      m_sum = 0;
      m_count = 0;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         R_FULL:    m_full = val[14:0];
         R_SERIES:  m_series = val;
         R_NOMINAL: m_nominal = val;
         R_BETA:    m_beta = val[15:0];
         default:   m_nomtemp = val[8:0];
      endcase
   endtask

   task automatic send_sample(logic signed [15:0] s, bit typed, reading_type w);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (req_stall);
      predict_sample(s, typed, w);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // a group of samples around a target average, with some spread
   task automatic send_group(int target, int spread);
      reading_type z;
      int v;
      z = '0;
      for (int i = 0; i < N_SAMPLES; i++) begin
         v = target + $urandom_range(0, 2 * spread) - spread;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         send_sample(16'(v), 0, z);
      end
   endtask

   // result checker and receiver idling
   always @(posedge clock) begin
      reading_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_average_q4, rsp_resistance_ohms, rsp_temperature_q8, rsp_status};
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_q.pop_front();
               if (typed_flag_q.pop_front() && typed_q[0] != want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("typed row %p vs predictor %p", typed_q[0], want);
               end
               void'(typed_q.pop_front());
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected avg %0d ohm %0d temp %0d st %0d, got %0d %0d %0d %0d",
                        results_seen, want.average_q4, want.resistance_ohms,
                        want.temperature_q8, want.status, got.average_q4,
                        got.resistance_ohms, got.temperature_q8, got.status);
               end
            end
         end
         // stall bursts; the counter holds rsp_stall for a burst
         if (no_idle) rsp_stall <= 1'b0;
         else if (stall_left > 0) stall_left <= stall_left - 1;
         else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(1, 16) - 1;
         end else rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   stim_row_type table_rows[$];

   function automatic void add_group(int value, bit typed, reading_type w);
      stim_row_type r;
      for (int i = 0; i < N_SAMPLES; i++) begin
         r.sample = 16'(value);
         r.typed  = (i == N_SAMPLES - 1) ? typed : 0;
         r.want   = w;
         table_rows.push_back(r);
      end
   endfunction

   initial begin
      reading_type zero_low, p;
      int sel;
      m_full = DEF_FULL_SCALE; m_series = DEF_SERIES; m_nominal = DEF_NOMINAL;
      m_beta = DEF_BETA; m_nomtemp = DEF_NOM_TEMP; m_sum = 0; m_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of the reading, error statuses, mid scale
      zero_low = '{19'd0, 32'd0, 18'sd0, ST_LOW};
      add_group(-32768, 1, zero_low);            // most negative
      add_group(0, 1, zero_low);                 // zero average
      add_group(32767, 1, '{19'd524272, 32'd0, 18'sd0, ST_HIGH}); // above full scale
      add_group(13200, 0, zero_low);             // mid scale
      add_group(1, 0, zero_low);                 // very hot
      foreach (table_rows[i]) send_sample(table_rows[i].sample, table_rows[i].typed,
                                          table_rows[i].want);
      // mixed-sign group exercises every sample bit
      p = '0;
      send_sample(16'sh5555, 0, p); send_sample(-16'sh5556, 0, p);
      send_sample(16'sh2AAA, 0, p); send_sample(16'sh0F0F, 0, p);
      send_sample(-16'sh0001, 0, p);
      go_idle();

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: ;
            1: begin
               write_reg(R_FULL, 15'd32767); write_reg(R_SERIES, 24'hFFFFFF);
               write_reg(R_NOMINAL, 24'd1); write_reg(R_BETA, 16'hFFFF);
               write_reg(R_NOMTEMP, 24'(9'sh1C9));   // -55 C
            end
            2: begin
               write_reg(R_FULL, 15'd1); write_reg(R_SERIES, 24'd1);
               write_reg(R_NOMINAL, 24'hFFFFFF); write_reg(R_BETA, 16'd1);
               write_reg(R_NOMTEMP, 24'd150);
            end
            3: begin
               // zero registers give the unusable-register status
               write_reg(R_SERIES, 24'd0); write_reg(R_FULL, 15'd26400);
               write_reg(R_NOMINAL, 24'd0); write_reg(R_BETA, 16'd0);
            end
            4: begin
               write_reg(R_FULL, 15'($urandom_range(1000, 32767)));
               write_reg(R_SERIES, 24'($urandom_range(1000, 16777215)));
               write_reg(R_NOMINAL, 24'($urandom_range(1000, 16777215)));
               write_reg(R_BETA, 16'($urandom_range(1000, 65535)));
               write_reg(R_NOMTEMP, 24'(9'($urandom_range(0, 205) - 55)));
            end
            default: begin
               write_reg(R_FULL, DEF_FULL_SCALE); write_reg(R_SERIES, DEF_SERIES);
               write_reg(R_NOMINAL, DEF_NOMINAL); write_reg(R_BETA, DEF_BETA);
               write_reg(R_NOMTEMP, 24'(DEF_NOM_TEMP));
               no_idle = 1;
            end
         endcase
         for (int g = 0; g < N_RANDOM / (6 * N_SAMPLES); g++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) send_group($urandom_range(1, m_full > 1 ? m_full - 1 : 1),
                                    $urandom_range(0, 300));
            else if (sel < 8) send_group($urandom_range(0, 65535) - 32768, 32767);
            else send_group(sel == 8 ? 0 : m_full, 2);
            if (g == 10 && ph == 0) go_idle();   // sender waits for all results
         end
         go_idle();
      end

      $display("covered %0d results over six register settings, %0d mismatches",
               results_seen, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

### files.f
+incdir+hdl
hdl/ntcb_pkg.sv
hdl/ntcb_div.sv
hdl/ntc_thermistor_beta_converter.sv
tb/ntc_thermistor_beta_converter_test.sv
